// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Shared assertion helpers for the deque checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assert a property sampled on the clock, masked during reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assert an implication that is also checked during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/pid_pkg.sv
// ----------------------------------------------------------------------------
// pid_pkg
// Status codes, request modes and state codes for the positional-insert deque.
// ----------------------------------------------------------------------------
package pid_pkg;

    localparam logic [1:0] MODE_PUSH_FRONT = 2'd0;
    localparam logic [1:0] MODE_PUSH_BACK  = 2'd1;
    localparam logic [1:0] MODE_INSERT     = 2'd2;
    localparam logic [1:0] MODE_POP        = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BADPOS = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_TAKE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_MOVE  = 3'd3;
    localparam logic [2:0] S_PLACE = 3'd4;
    localparam logic [2:0] S_FRONT = 3'd5;
    localparam logic [2:0] S_BACK  = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

endpackage

// File: src/positional_insert_deque.sv
// ----------------------------------------------------------------------------
// positional_insert_deque
// Ordered queue of identifiers with push front/back, positional insert, pop.
// ----------------------------------------------------------------------------
// Entries live in one synchronous RAM (registered read) with the front at
// address 0. One request is in work at a time; s_axis_tready is high only while
// idle. An insert moves the k entries behind the insert point one slot back, a
// pop reads the front and moves the k = count-1 remaining entries one slot
// forward; each move is a read in S_READ and a write in S_MOVE on the single RAM
// port pair. Front and back are then read for the result word. A rejected
// request (full, empty, position zero) skips the moves. S_OUT loads the result
// word into the output register once the previous word has left it, and the
// next word can be accepted once the block is back in S_IDLE.
module positional_insert_deque #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_WIDTH    = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // mode[1:0], item_id[17:2], position[25:18]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata   // status[1:0], popped_id[17:2], nonempty[18],
                                       // front_id[34:19], back_id[50:35], entry_count[55:51]
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int PW = (CW > 8) ? CW + 1 : 9;

    logic [ID_WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [ID_WIDTH-1:0] r_rd;
    logic [AW-1:0]       rd_addr, wr_addr;
    logic                wr_en;
    logic [ID_WIDTH-1:0] wr_data;

    logic [2:0]          r_state, n_state;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [1:0]          r_mode;
    logic [ID_WIDTH-1:0] r_id;
    logic [CW-1:0]       r_idx, r_ptr;
    logic [1:0]          r_status;
    logic [15:0]         r_popped;
    logic [ID_WIDTH-1:0] r_front;
    logic                r_ovalid;
    logic [55:0]         r_odata;

    logic [1:0]    in_mode;
    logic [15:0]   in_id;
    logic [7:0]    in_pos;
    logic [PW-1:0] pos_m1;
    logic [1:0]    in_status;
    logic [CW-1:0] in_idx;
    logic [CW-1:0] ptr_inc;
    logic          accept, out_free;
    logic [15:0]   front16, back16;

    assign in_mode = s_axis_tdata[1:0];
    assign in_id   = s_axis_tdata[17:2];
    assign in_pos  = s_axis_tdata[25:18];
    assign pos_m1  = PW'(in_pos) - PW'(1);
    assign ptr_inc = r_ptr + CW'(1);

    assign s_axis_tready = (r_state == pid_pkg::S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_ovalid || m_axis_tready;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        r_rd <= r_mem[rd_addr];
    end

    assign front16 = 16'(r_front);
    assign back16  = 16'(r_rd);

    always_comb begin
        in_status = pid_pkg::ST_OK;
        if (in_mode == pid_pkg::MODE_POP) begin
            if (r_cnt == '0) in_status = pid_pkg::ST_EMPTY;
        end else if (in_mode == pid_pkg::MODE_INSERT && in_pos == 8'd0) begin
            in_status = pid_pkg::ST_BADPOS;
        end else if (r_cnt >= CW'(QUEUE_DEPTH)) begin
            in_status = pid_pkg::ST_FULL;
        end
        unique case (in_mode)
            pid_pkg::MODE_PUSH_FRONT: in_idx = '0;
            pid_pkg::MODE_INSERT:     in_idx = (pos_m1 < PW'(r_cnt)) ? pos_m1[CW-1:0] : r_cnt;
            default:                  in_idx = r_cnt;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        rd_addr = AW'(r_cnt - CW'(1));
        wr_addr = r_ptr[AW-1:0];
        wr_en   = 1'b0;
        wr_data = r_rd;
        unique case (r_state)
            pid_pkg::S_IDLE: begin
                // front is fetched on the accepting edge for a pop
                rd_addr = '0;
                if (accept) begin
                    if (in_status != pid_pkg::ST_OK) n_state = pid_pkg::S_FRONT;
                    else if (in_mode == pid_pkg::MODE_POP) n_state = pid_pkg::S_TAKE;
                    else n_state = pid_pkg::S_READ;
                end
            end
            pid_pkg::S_TAKE: n_state = pid_pkg::S_READ;
            pid_pkg::S_READ: begin
                if (r_mode == pid_pkg::MODE_POP) begin
                    if (ptr_inc < r_cnt) begin
                        rd_addr = ptr_inc[AW-1:0];
                        n_state = pid_pkg::S_MOVE;
                    end else begin
                        n_cnt   = r_cnt - CW'(1);
                        n_state = pid_pkg::S_FRONT;
                    end
                end else if (r_ptr > r_idx) begin
                    rd_addr = AW'(r_ptr - CW'(1));
                    n_state = pid_pkg::S_MOVE;
                end else begin
                    n_state = pid_pkg::S_PLACE;
                end
            end
            pid_pkg::S_MOVE: begin
                wr_en   = 1'b1;
                n_state = pid_pkg::S_READ;
            end
            pid_pkg::S_PLACE: begin
                wr_en   = 1'b1;
                wr_addr = r_idx[AW-1:0];
                wr_data = r_id;
                n_cnt   = r_cnt + CW'(1);
                n_state = pid_pkg::S_FRONT;
            end
            pid_pkg::S_FRONT: begin
                rd_addr = '0;
                n_state = pid_pkg::S_BACK;
            end
            pid_pkg::S_BACK: n_state = pid_pkg::S_OUT;
            pid_pkg::S_OUT: begin
                if (out_free) n_state = pid_pkg::S_IDLE;
            end
            default: n_state = pid_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pid_pkg::S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (r_state == pid_pkg::S_OUT && out_free) r_ovalid <= 1'b1;
            else if (m_axis_tready) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            pid_pkg::S_IDLE: begin
                if (accept) begin
                    r_mode   <= in_mode;
                    r_id     <= ID_WIDTH'(in_id);
                    r_status <= in_status;
                    r_popped <= '0;
                    r_idx    <= in_idx;
                    r_ptr    <= (in_mode == pid_pkg::MODE_POP) ? '0 : r_cnt;
                end
            end
            pid_pkg::S_TAKE: r_popped <= 16'(r_rd);
            pid_pkg::S_MOVE: begin
                if (r_mode == pid_pkg::MODE_POP) r_ptr <= r_ptr + CW'(1);
                else r_ptr <= r_ptr - CW'(1);
            end
            pid_pkg::S_BACK: r_front <= r_rd;
            pid_pkg::S_OUT: begin
                if (out_free) begin
                    r_odata <= {5'(r_cnt),
                                (r_cnt != '0) ? back16 : 16'd0,
                                (r_cnt != '0) ? front16 : 16'd0,
                                (r_cnt != '0), r_popped, r_status};
                end
            end
            default: ;
        endcase
    end

endmodule

// File: src/pid_checker.sv
// ----------------------------------------------------------------------------
// pid_checker
// Port-level checks for the positional-insert deque.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pid_checker #(
    parameter int QUEUE_DEPTH = 16
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata
);

    logic       stall;
    logic [4:0] out_cnt;
    logic       out_nonempty;

    assign stall        = m_axis_tvalid && !m_axis_tready;
    assign out_cnt      = m_axis_tdata[55:51];
    assign out_nonempty = m_axis_tdata[18];

    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, stall |=> $stable(m_axis_tdata), "word not held")
    `ASSERT_CLK(a_valid_hold, i_clk, i_rst_n, stall |=> m_axis_tvalid, "valid dropped")
    `ASSERT_CLK(a_cnt_range, i_clk, i_rst_n, m_axis_tvalid |-> out_cnt <= QUEUE_DEPTH, "count")
    `ASSERT_CLK(a_nonempty, i_clk, i_rst_n, m_axis_tvalid && out_cnt != '0 |-> out_nonempty, "flag")
    `ASSERT_ALWAYS(a_rst_idle, i_clk, !i_rst_n |=> !m_axis_tvalid, "output valid after reset")

endmodule

bind positional_insert_deque pid_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_pid_checker (.*);

// File: dv/pid_checker.sv
// ----------------------------------------------------------------------------
// pid_scoreboard
// Watches both streams of the positional-insert deque, predicts each result
// word from an internal copy of the queue and compares it field by field.
// ----------------------------------------------------------------------------
module pid_scoreboard #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_WIDTH    = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [31:0] i_req_data,
    input  logic        i_rsp_valid,
    input  logic        i_rsp_ready,
    input  logic [55:0] i_rsp_data,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [4:0]  entry_count;
        logic [15:0] back_id;
        logic [15:0] front_id;
        logic        nonempty;
        logic [15:0] popped_id;
        logic [1:0]  status;
    } t_result;

    logic [15:0] model_q[$];
    t_result     expected_q[$];

    function automatic t_result apply_request(logic [31:0] req);
        logic [1:0]  mode;
        logic [15:0] id;
        int unsigned pos;
        int unsigned idx;
        t_result     r;
        mode = req[1:0];
        id   = req[17:2] & 16'((64'h1 << ID_WIDTH) - 64'h1);
        pos  = 32'(req[25:18]);
        r    = '0;
        r.status = pid_pkg::ST_OK;
        if (mode == pid_pkg::MODE_POP) begin
            if (model_q.size() == 0) begin
                r.status = pid_pkg::ST_EMPTY;
            end else begin
                r.popped_id = model_q.pop_front();
            end
        end else if (mode == pid_pkg::MODE_INSERT && pos == 0) begin
            r.status = pid_pkg::ST_BADPOS;
        end else if (model_q.size() >= QUEUE_DEPTH) begin
            r.status = pid_pkg::ST_FULL;
        end else begin
            if (mode == pid_pkg::MODE_PUSH_FRONT) idx = 0;
            else if (mode == pid_pkg::MODE_PUSH_BACK) idx = unsigned'(model_q.size());
            else idx = (pos - 1 < unsigned'(model_q.size())) ? pos - 1
                                                              : unsigned'(model_q.size());
            model_q.insert(idx, id);
        end
        r.nonempty    = model_q.size() != 0;
        r.front_id    = r.nonempty ? model_q[0] : '0;
        r.back_id     = r.nonempty ? model_q[$] : '0;
        r.entry_count = 5'(model_q.size());
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            o_errors = 0;
            model_q.delete();
            expected_q.delete();
        end else begin
            if (i_req_valid && i_req_ready) expected_q.push_back(apply_request(i_req_data));
            if (i_rsp_valid && i_rsp_ready) begin
                got = i_rsp_data;
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected word", 32'(got.status), 32'd0);
                end else begin
                    want = expected_q.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", 32'(got.status), 32'(want.status));
                    if (got.popped_id !== want.popped_id)
                        report_mismatch("popped_id", 32'(got.popped_id), 32'(want.popped_id));
                    if (got.nonempty !== want.nonempty)
                        report_mismatch("nonempty", 32'(got.nonempty), 32'(want.nonempty));
                    if (got.front_id !== want.front_id)
                        report_mismatch("front_id", 32'(got.front_id), 32'(want.front_id));
                    if (got.back_id !== want.back_id)
                        report_mismatch("back_id", 32'(got.back_id), 32'(want.back_id));
                    if (got.entry_count !== want.entry_count)
                        report_mismatch("entry_count", 32'(got.entry_count),
                                        32'(want.entry_count));
                end
            end
        end
        o_pending = expected_q.size();
    end
endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random deque requests with random gaps and stalls,
// including a long output hold-off and a drain pause, then gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH     = 16;
    localparam int IDLE_MAX  = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // mode, item_id, position
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;        // status, popped_id, nonempty, front, back, count
    int          errors;
    int          pending;
    bit          hold_off = 1'b0;
    int          occupancy_guess = 0;
    int          idle_cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    positional_insert_deque #(.QUEUE_DEPTH(DEPTH), .ID_WIDTH(16)) dut (.*);

    pid_scoreboard #(.QUEUE_DEPTH(DEPTH), .ID_WIDTH(16)) checker_i (
        .i_clk, .i_rst_n,
        .i_req_valid(s_axis_tvalid), .i_req_ready(s_axis_tready), .i_req_data(s_axis_tdata),
        .i_rsp_valid(m_axis_tvalid), .i_rsp_ready(m_axis_tready), .i_rsp_data(m_axis_tdata),
        .o_errors(errors), .o_pending(pending)
    );

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_word(logic [1:0] mode, logic [15:0] id, logic [7:0] pos);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, pos, id, mode};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (mode == pid_pkg::MODE_POP) begin
            if (occupancy_guess > 0) occupancy_guess--;
        end else if (!(mode == pid_pkg::MODE_INSERT && pos == 0) && occupancy_guess < DEPTH) begin
            occupancy_guess++;
        end
    endtask

    task automatic send_gap();
        int n;
        n = gap_len();
        if (n > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic send_random();
        logic [1:0] mode;
        int r;
        r = $urandom_range(0, 99);
        if (occupancy_guess > 12)
            mode = (r < 55) ? pid_pkg::MODE_POP : 2'($urandom_range(0, 2));
        else if (occupancy_guess < 3)
            mode = (r < 15) ? pid_pkg::MODE_POP : 2'($urandom_range(0, 2));
        else mode = 2'($urandom_range(0, 3));
        r = $urandom_range(0, 9);
        send_word(mode, 16'($urandom),
                  r == 0 ? 8'd0 : r < 8 ? 8'($urandom_range(1, occupancy_guess + 2))
                                        : 8'($urandom));
        send_gap();
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // receiver: random stalls plus one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n || hold_off) m_axis_tready <= 1'b0;
        else m_axis_tready <= ($urandom_range(0, 99) < 8) ? 1'b0 : 1'b1;
    end

    // watchdog on accepted words
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_MAX) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty pop, bad position, extremes, fill to full, drain
        send_word(pid_pkg::MODE_POP, 16'hFFFF, 8'hFF);
        send_word(pid_pkg::MODE_INSERT, 16'h1234, 8'd0);
        send_word(pid_pkg::MODE_INSERT, 16'hFFFF, 8'd1);
        send_word(pid_pkg::MODE_PUSH_BACK, 16'h0000, 8'hFF);
        send_word(pid_pkg::MODE_INSERT, 16'hAAAA, 8'hFF);
        send_word(pid_pkg::MODE_INSERT, 16'h5555, 8'd2);
        send_word(pid_pkg::MODE_PUSH_FRONT, 16'h8001, 8'd0);
        for (int i = 0; i < 12; i++) send_word(2'($urandom_range(0, 2)), 16'($urandom), 8'd3);
        send_word(pid_pkg::MODE_PUSH_FRONT, 16'h7777, 8'd1);
        send_word(pid_pkg::MODE_INSERT, 16'h6666, 8'd0);
        for (int i = 0; i < 4; i++) send_word(pid_pkg::MODE_POP, 16'h0, 8'h0);
        drain();

        // long receiver hold-off while the sender keeps offering
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 30; i++) send_random();
        join
        drain();

        for (int i = 0; i < 800; i++) begin
            if (i == 400) drain();
            if ((i % 150) == 149) begin
                while (occupancy_guess > 0)
                    send_word(pid_pkg::MODE_POP, 16'($urandom), 8'($urandom));
                send_word(pid_pkg::MODE_POP, 16'($urandom), 8'($urandom));
            end
            send_random();
        end
        drain();
        repeat (100) @(posedge i_clk);

        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

// File: sim.f
+incdir+src
src/pid_pkg.sv
src/positional_insert_deque.sv
src/pid_checker.sv
dv/pid_checker.sv
dv/tb_top.sv
